@@ design/triangle_face_normal_unit_assert.svh @@
// assertion macros shared by the face normal checker
`ifndef TRIANGLE_FACE_NORMAL_UNIT_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is low
`define TFN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("face normal check failed");

// next-cycle implication, off while reset is low
`define TFN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("face normal check failed");

// property checked during reset as well
`define TFN_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("face normal check failed");

`endif

@@ design/tfn_pkg.sv @@
// shared constants and types of the triangle face normal unit
package tfn_pkg;
	localparam int TFN_COORD_WIDTH = 16;
	localparam int TFN_FRAC_BITS = 14;
	localparam int SCALE_MSB = 29;
	localparam int SCALED_W = SCALE_MSB + 1;
	localparam int OUT_W = 16;
	localparam int QUEUE_DEPTH = 4;

	// one classified request between front and back
	typedef struct packed {
		logic [SCALED_W-1:0] m0;
		logic [SCALED_W-1:0] m1;
		logic [SCALED_W-1:0] m2;
		logic [2:0]          neg;
		logic                degen;
	} tfn_item_t;

	typedef struct packed {
		logic valid;
		logic full;
	} tfn_qstat_t;
endpackage

@@ design/tfn_front.sv @@
// front end: edges, cross product, magnitudes and common scaling
module tfn_front import tfn_pkg::*; #(
	parameter int COORD_WIDTH = TFN_COORD_WIDTH
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]        in_data,
	input  tfn_qstat_t                                qstat,
	output logic                                      push,
	output tfn_item_t                                 item
);
	localparam int CW = COORD_WIDTH;
	localparam int EW = CW + 1;
	localparam int PW = 2 * EW;
	localparam int NW = 2 * CW + 3;
	localparam int MW = 2 * CW + 2;
	localparam int LW = $clog2(MW);
	localparam int XW = MW + SCALE_MSB;

	logic [6:0] fv_q;
	logic       adv;

	logic signed [CW-1:0] crd [0:8];
	logic signed [EW-1:0] e_s1 [0:2];
	logic signed [EW-1:0] f_s1 [0:2];
	logic signed [PW-1:0] p_s2 [0:5];
	logic signed [NW-1:0] n_s3 [0:2];
	logic [MW-1:0]        m_s4 [0:2];
	logic [2:0]           neg_s4;
	logic [MW-1:0]        m_s5 [0:2];
	logic [2:0]           neg_s5;
	logic [MW-1:0]        big_s5;
	logic                 dg_s5;
	logic [MW-1:0]        m_s6 [0:2];
	logic [2:0]           neg_s6;
	logic                 dg_s6;
	logic [LW-1:0]        lead_s6;
	logic [LW-1:0]        lead;
	logic [MW-1:0]        big01;
	logic [XW-1:0]        shf [0:2];
	tfn_item_t            item_s7;

	assign adv      = !fv_q[6] || !qstat.full;
	assign in_ready = adv;
	assign push     = fv_q[6] && !qstat.full;
	assign item     = item_s7;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			crd[i] = $signed(in_data[i*CW +: CW]);
		end
	end

	always_comb begin
		big01 = (m_s4[1] > m_s4[0]) ? m_s4[1] : m_s4[0];
	end

	// position of the leading one of the largest magnitude
	always_comb begin
		lead = '0;
		for (int i = 0; i < MW; i++) begin
			if (big_s5[i]) lead = LW'(i);
		end
	end

	// common shift brings the largest magnitude to bit SCALE_MSB
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			shf[i] = {m_s6[i], {SCALE_MSB{1'b0}}} >> lead_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= '0;
		end else if (adv) begin
			fv_q <= {fv_q[5:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				e_s1[i] <= EW'(crd[3+i]) - EW'(crd[i]);
				f_s1[i] <= EW'(crd[6+i]) - EW'(crd[i]);
			end
			p_s2[0] <= e_s1[1] * f_s1[2];
			p_s2[1] <= e_s1[2] * f_s1[1];
			p_s2[2] <= e_s1[2] * f_s1[0];
			p_s2[3] <= e_s1[0] * f_s1[2];
			p_s2[4] <= e_s1[0] * f_s1[1];
			p_s2[5] <= e_s1[1] * f_s1[0];
			for (int i = 0; i < 3; i++) begin
				n_s3[i]   <= NW'(p_s2[2*i]) - NW'(p_s2[2*i+1]);
				neg_s4[i] <= n_s3[i][NW-1];
				m_s4[i]   <= n_s3[i][NW-1] ? MW'(-n_s3[i]) : MW'(n_s3[i]);
				m_s5[i]   <= m_s4[i];
				m_s6[i]   <= m_s5[i];
			end
			neg_s5  <= neg_s4;
			big_s5  <= (m_s4[2] > big01) ? m_s4[2] : big01;
			dg_s5   <= (m_s4[0] == '0) && (m_s4[1] == '0) && (m_s4[2] == '0);
			neg_s6  <= neg_s5;
			dg_s6   <= dg_s5;
			lead_s6 <= lead;
			item_s7.m0    <= shf[0][SCALED_W-1:0];
			item_s7.m1    <= shf[1][SCALED_W-1:0];
			item_s7.m2    <= shf[2][SCALED_W-1:0];
			item_s7.neg   <= neg_s6;
			item_s7.degen <= dg_s6;
		end
	end
endmodule

@@ design/tfn_queue.sv @@
// short register queue between front and back
module tfn_queue import tfn_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tfn_item_t  push_item,
	input  logic       pop,
	output tfn_qstat_t qstat,
	output tfn_item_t  head
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	tfn_item_t      mem_q [0:DEPTH-1];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CNW-1:0] cnt_q;

	assign qstat.valid = (cnt_q != '0);
	assign qstat.full  = (cnt_q == CNW'(DEPTH));
	assign head        = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end
endmodule

@@ design/tfn_back.sv @@
// back end: sum of squares, pipelined square root and dividers
module tfn_back import tfn_pkg::*; #(
	parameter int NORMAL_FRAC_BITS = TFN_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tfn_qstat_t          qstat,
	input  tfn_item_t           head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [OUT_W-1:0]    nx,
	output logic [OUT_W-1:0]    ny,
	output logic [OUT_W-1:0]    nz,
	output logic                degen
);
	localparam int FB  = NORMAL_FRAC_BITS;
	localparam int SQW = 2 * SCALED_W;
	localparam int SW  = SQW + 2;
	localparam int RW  = SW / 2;
	localparam int NR  = RW;
	localparam int QW  = FB + 1;
	localparam int DW  = FB + SCALED_W + 1;
	localparam int NB  = 3 + NR + QW + 2;

	logic [NB-1:0] bv_q;
	logic          adv;

	logic [SCALED_W-1:0] m_s0 [0:2];
	logic [2:0]          neg_s0;
	logic                dg_s0;
	logic [SQW-1:0]      sq_s1 [0:2];
	logic [SCALED_W-1:0] m_s1 [0:2];
	logic [2:0]          neg_s1;
	logic                dg_s1;
	logic [SW-1:0]       sum_s2;
	logic [SCALED_W-1:0] m_s2 [0:2];
	logic [2:0]          neg_s2;
	logic                dg_s2;

	// square root stages, one root bit each
	logic [SW-1:0]       rem_sr  [0:NR-1];
	logic [RW-1:0]       root_sr [0:NR-1];
	logic [SCALED_W-1:0] m_sr    [0:NR-1][0:2];
	logic [2:0]          neg_sr  [0:NR-1];
	logic                dg_sr   [0:NR-1];
	logic [SW-1:0]       rem_nx  [0:NR-1];
	logic [RW-1:0]       root_nx [0:NR-1];

	// divider stages, one quotient bit each; index 0 holds the dividends
	logic [DW-1:0] dd_sd [0:QW][0:2];
	logic [QW-1:0] q_sd  [0:QW][0:2];
	logic [RW-1:0] l_sd  [0:QW];
	logic [2:0]    neg_sd [0:QW];
	logic          dg_sd  [0:QW];
	logic [DW-1:0] dd_nx [0:QW-1][0:2];
	logic [QW-1:0] q_nx  [0:QW-1][0:2];

	logic [31:0]      sgn [0:2];
	logic [OUT_W-1:0] nx_q, ny_q, nz_q;
	logic             dg_q;

	assign adv       = !bv_q[NB-1] || out_ready;
	assign pop       = qstat.valid && adv;
	assign out_valid = bv_q[NB-1];
	assign nx        = nx_q;
	assign ny        = ny_q;
	assign nz        = nz_q;
	assign degen     = dg_q;

	always_comb begin
		logic [SW+1:0] rin;
		logic [RW-1:0] tin;
		logic [SW+1:0] dlt;
		for (int k = 0; k < NR; k++) begin
			rin = (k == 0) ? (SW+2)'(sum_s2) : (SW+2)'(rem_sr[(k == 0) ? 0 : k-1]);
			tin = (k == 0) ? '0 : root_sr[(k == 0) ? 0 : k-1];
			dlt = ((SW+2)'(tin) << (RW - k)) | ((SW+2)'(1) << (2 * (RW - 1 - k)));
			if (rin >= dlt) begin
				rem_nx[k]  = SW'(rin - dlt);
				root_nx[k] = tin | (RW'(1) << (RW - 1 - k));
			end else begin
				rem_nx[k]  = SW'(rin);
				root_nx[k] = tin;
			end
		end
	end

	always_comb begin
		logic [DW-1:0] dv;
		for (int j = 0; j < QW; j++) begin
			dv = DW'(l_sd[j]) << (QW - 1 - j);
			for (int i = 0; i < 3; i++) begin
				if (dd_sd[j][i] >= dv) begin
					dd_nx[j][i] = dd_sd[j][i] - dv;
					q_nx[j][i]  = q_sd[j][i] | (QW'(1) << (QW - 1 - j));
				end else begin
					dd_nx[j][i] = dd_sd[j][i];
					q_nx[j][i]  = q_sd[j][i];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sgn[i] = neg_sd[QW][i] ? -32'(q_sd[QW][i]) : 32'(q_sd[QW][i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_q <= '0;
		end else if (adv) begin
			bv_q <= {bv_q[NB-2:0], pop};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s0[0] <= head.m0;
			m_s0[1] <= head.m1;
			m_s0[2] <= head.m2;
			neg_s0  <= head.neg;
			dg_s0   <= head.degen;
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= SQW'(m_s0[i]) * SQW'(m_s0[i]);
				m_s1[i]  <= m_s0[i];
				m_s2[i]  <= m_s1[i];
			end
			neg_s1 <= neg_s0;
			dg_s1  <= dg_s0;
			sum_s2 <= SW'(sq_s1[0]) + SW'(sq_s1[1]) + SW'(sq_s1[2]);
			neg_s2 <= neg_s1;
			dg_s2  <= dg_s1;
			for (int k = 0; k < NR; k++) begin
				rem_sr[k]  <= rem_nx[k];
				root_sr[k] <= root_nx[k];
				for (int i = 0; i < 3; i++) begin
					m_sr[k][i] <= (k == 0) ? m_s2[i] : m_sr[(k == 0) ? 0 : k-1][i];
				end
				neg_sr[k] <= (k == 0) ? neg_s2 : neg_sr[(k == 0) ? 0 : k-1];
				dg_sr[k]  <= (k == 0) ? dg_s2 : dg_sr[(k == 0) ? 0 : k-1];
			end
			// dividend: scaled magnitude plus half the length, rounds to nearest
			for (int i = 0; i < 3; i++) begin
				dd_sd[0][i] <= (DW'(m_sr[NR-1][i]) << FB) + DW'(root_sr[NR-1] >> 1);
				q_sd[0][i]  <= '0;
			end
			l_sd[0]   <= root_sr[NR-1];
			neg_sd[0] <= neg_sr[NR-1];
			dg_sd[0]  <= dg_sr[NR-1];
			for (int j = 0; j < QW; j++) begin
				for (int i = 0; i < 3; i++) begin
					dd_sd[j+1][i] <= dd_nx[j][i];
					q_sd[j+1][i]  <= q_nx[j][i];
				end
				l_sd[j+1]   <= l_sd[j];
				neg_sd[j+1] <= neg_sd[j];
				dg_sd[j+1]  <= dg_sd[j];
			end
			nx_q <= dg_sd[QW] ? '0 : sgn[0][OUT_W-1:0];
			ny_q <= dg_sd[QW] ? '0 : sgn[1][OUT_W-1:0];
			nz_q <= dg_sd[QW] ? '0 : sgn[2][OUT_W-1:0];
			dg_q <= dg_sd[QW];
		end
	end
endmodule

@@ design/triangle_face_normal_unit.sv @@
// top level of the triangle face normal unit
// usage:
//   slave channel s_axis takes one triangle per request: nine signed Q8.8
//   coordinates, corner a then b then c, x y z each
//   master channel m_axis gives one unit normal per request, signed Q1.14
//   components, tuser high marks a degenerate triangle with a zero normal
// throughput: one triangle per cycle while m_axis_tready is high, fully
//   pipelined in front and back
// path from acceptance to tvalid: 7 front stages, the queue, then the 3 entry
//   stages, 31 square root stages, the dividend register, NORMAL_FRAC_BITS + 1
//   divider stages and the output register of the back end
// front end (7 stages) forms edges, cross product and common scaling, then
//   drops each request into a 4-entry queue; the back end pops it when it can
// when a result waits on m_axis_tready the back pipeline holds, the queue
//   fills, and then the front holds and s_axis_tready goes low; nothing is dropped
// reset clears all valid flags and queue pointers; no clearing pass is needed
module triangle_face_normal_unit import tfn_pkg::*; #(
	parameter int COORD_WIDTH      = TFN_COORD_WIDTH,
	parameter int NORMAL_FRAC_BITS = TFN_FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// corner_a_x, corner_a_y, corner_a_z, corner_b_x .. corner_c_z, zero fill
	input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// normal_x, normal_y, normal_z
	output logic [3*OUT_W-1:0]                 m_axis_tdata,
	// degenerate
	output logic [0:0]                         m_axis_tuser
);
	tfn_qstat_t       qstat;
	tfn_item_t        fr_item;
	tfn_item_t        q_head;
	logic             fr_push;
	logic             bk_pop;
	logic [OUT_W-1:0] nx, ny, nz;
	logic             degen;

	// classify: edges, cross product, signs and scaled magnitudes
	tfn_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.qstat    (qstat),
		.push     (fr_push),
		.item     (fr_item)
	);

	// decouples the two halves so each can stall on its own
	tfn_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fr_push),
		.push_item (fr_item),
		.pop       (bk_pop),
		.qstat     (qstat),
		.head      (q_head)
	);

	// length and division, ends in the output register
	tfn_back #(
		.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head      (q_head),
		.pop       (bk_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.nx        (nx),
		.ny        (ny),
		.nz        (nz),
		.degen     (degen)
	);

	assign m_axis_tdata = {nz, ny, nx};
	assign m_axis_tuser = degen;
endmodule

@@ design/tfn_checker.sv @@
// port checker for the face normal unit and its bind
`include "triangle_face_normal_unit_assert.svh"

module tfn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);
	// stalled result stays put
	`TFN_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
	// degenerate triangle gives a zero normal
	`TFN_ASSERT_NOW(a_degen_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 48'd0)
	// no result right out of reset
	`TFN_ASSERT_ALWAYS(a_reset_idle, clk, $rose(arst_n) |-> !m_axis_tvalid)
endmodule

bind triangle_face_normal_unit tfn_checker u_tfn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
